// ----- design/skt_pkg.sv -----
// shared types and codes for the sorted key table
package skt_pkg;

    localparam int KEY_W   = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 56;
    localparam int COUNT_W = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PRESENT = 2'd1;
    localparam logic [1:0] STAT_ABSENT  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // packed in m_tdata order, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] slot_index;
        logic [31:0]        read_value;
        logic               found;
        logic [1:0]         status;
    } result_t;

endpackage

// ----- design/sorted_key_table_unit.sv -----
// sorted key table: binary search and shift sequencer over one entry ram
//
//  channel | dir | ports                       | word contents
//  --------+-----+-----------------------------+----------------------------------------
//  s_      | in  | tvalid tready tdata tuser   | tdata: search_key, entry_value
//          |     |                             | tuser: kind
//  m_      | out | tvalid tready tdata         | tdata: status, found, read_value,
//          |     |                             |        slot_index, entry_count
//
//  one word at a time: after the accept a word passes search, p probes and decide; reply then
//  hands the result to the output register and the next word is taken back in idle;
//  p probes, at most clog2(CAPACITY) + 1; an insert or erase that moves m entries shifts them
//  before the reply, one ram read and one write per cycle, and an insert then stores the new entry
//  no clearing pass after reset: only entries below the fill count are ever read
//  the next word is taken while a result waits; reply stalls while that register is full and m_tready low
module sorted_key_table_unit #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [skt_pkg::IN_W-1:0]    s_tdata,   // search_key, entry_value
    input  logic [1:0]                  s_tuser,   // kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [skt_pkg::OUT_W-1:0]   m_tdata    // status, found, read_value, slot_index,
                                                   // entry_count, zero pad
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int ENT_W = skt_pkg::KEY_W + VALUE_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_PROBE  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_STORE  = 7'b0100000,
        S_REPLY  = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    op_reg, op_next;
    logic signed [skt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0]        val_reg, val_next;
    logic [CNT_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;
    logic [AW-1:0]                 probe_reg, probe_next;
    logic                          hit_reg, hit_next;
    logic [VALUE_WIDTH-1:0]        hit_val_reg, hit_val_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          wr_pend_reg, wr_pend_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic [1:0]                    status_reg, status_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [ENT_W-1:0]              ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [ENT_W-1:0]              ram_rdata;

    logic signed [skt_pkg::KEY_W-1:0] rd_key;
    logic [VALUE_WIDTH-1:0]        rd_val;
    logic [CNT_W-1:0]              cur_lo, cur_hi, mid;
    logic                          shift_more;
    logic [CNT_W-1:0]              shift_src, shift_dst, shift_idx;

    logic                          res_valid, res_ready;
    skt_pkg::result_t              res;

    assign rd_key = ram_rdata[skt_pkg::KEY_W-1:0];
    assign rd_val = ram_rdata[ENT_W-1:skt_pkg::KEY_W];

    // search window after this cycle's probe compare
    always_comb begin
        cur_lo = lo_reg;
        cur_hi = hi_reg;
        if (state_reg == S_PROBE) begin
            if (rd_key < key_reg) begin
                cur_lo = CNT_W'(probe_reg) + CNT_W'(1);
            end else begin
                cur_hi = CNT_W'(probe_reg);
            end
        end
    end

    assign mid = cur_lo + ((cur_hi - cur_lo) >> 1);

    always_comb begin
        if (op_reg == skt_pkg::OP_INSERT) begin
            shift_more = idx_reg > lo_reg;
            shift_src  = idx_reg - CNT_W'(1);
            shift_dst  = idx_reg;
            shift_idx  = idx_reg - CNT_W'(1);
        end else begin
            shift_more = idx_reg < count_reg;
            shift_src  = idx_reg;
            shift_dst  = idx_reg - CNT_W'(1);
            shift_idx  = idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        probe_next   = probe_reg;
        hit_next     = hit_reg;
        hit_val_next = hit_val_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = AW'(mid);
        res_valid    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[31:0];
                    val_next   = VALUE_WIDTH'(s_tdata[63:32]);
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH, S_PROBE: begin
                if (state_reg == S_PROBE && rd_key == key_reg) begin
                    hit_next     = 1'b1;
                    hit_val_next = rd_val;
                end
                lo_next = cur_lo;
                hi_next = cur_hi;
                if (cur_lo < cur_hi) begin
                    ram_re     = 1'b1;
                    probe_next = AW'(mid);
                    state_next = S_PROBE;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_REPLY;
                case (op_reg)
                    skt_pkg::OP_INSERT: begin
                        if (hit_reg) begin
                            status_next = skt_pkg::STAT_PRESENT;
                        end else if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = skt_pkg::STAT_FULL;
                        end else begin
                            status_next = skt_pkg::STAT_OK;
                            idx_next    = count_reg;
                            state_next  = S_SHIFT;
                        end
                    end
                    skt_pkg::OP_ERASE: begin
                        if (!hit_reg) begin
                            status_next = skt_pkg::STAT_ABSENT;
                        end else begin
                            status_next = skt_pkg::STAT_OK;
                            idx_next    = lo_reg + CNT_W'(1);
                            state_next  = S_SHIFT;
                        end
                    end
                    default: begin
                        status_next = hit_reg ? skt_pkg::STAT_OK : skt_pkg::STAT_ABSENT;
                    end
                endcase
            end
            S_SHIFT: begin
                // read one entry, write it one slot over in the next cycle
                ram_we = wr_pend_reg;
                if (shift_more) begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(shift_src);
                    wr_pend_next = 1'b1;
                    wr_addr_next = AW'(shift_dst);
                    idx_next     = shift_idx;
                end else if (!wr_pend_reg) begin
                    if (op_reg == skt_pkg::OP_INSERT) begin
                        state_next = S_STORE;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_REPLY;
                    end
                end
            end
            S_STORE: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(lo_reg);
                ram_wdata  = {val_reg, key_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = S_REPLY;
            end
            S_REPLY: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        probe_reg   <= probe_next;
        hit_val_reg <= hit_val_next;
        idx_reg     <= idx_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        res             = '0;
        res.status      = status_reg;
        res.found       = hit_reg;
        res.slot_index  = skt_pkg::COUNT_W'(lo_reg);
        res.entry_count = skt_pkg::COUNT_W'(count_reg);
        if (hit_reg && op_reg != skt_pkg::OP_INSERT && op_reg != skt_pkg::OP_ERASE) begin
            res.read_value = 32'(hit_val_reg);
        end
    end

    skt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- design/skt_ram.sv -----
// generic single write port, single read port ram with registered read
module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/skt_out_stage.sv -----
// result register between the sequencer and the master channel
module skt_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       res_valid,
    input  skt_pkg::result_t           res,
    output logic                       res_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [skt_pkg::OUT_W-1:0]  m_tdata
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [skt_pkg::OUT_W-1:0] data_reg;

    assign res_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- design/skt_checker.sv -----
// port level checks for the sorted key table, bound to the top level
module skt_checker #(
    parameter int CAPACITY = 64
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [skt_pkg::OUT_W-1:0] m_tdata
);

    skt_pkg::result_t r;

    assign r = m_tdata;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_status_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status != skt_pkg::STAT_OK |->
            r.found == (r.status == skt_pkg::STAT_PRESENT))
        else $error("found flag disagrees with status");

    a_value_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.read_value != 32'd0 |-> r.found && r.status == skt_pkg::STAT_OK)
        else $error("value returned without a lookup hit");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && s_tvalid |-> (CAPACITY > 127) ||
            (r.slot_index <= r.entry_count && r.entry_count <= CAPACITY))
        else $error("slot or entry count out of range");

endmodule

bind sorted_key_table_unit skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb.sv -----
// testbench for the sorted key table: stream stimulus, shadow table and result checking
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH = 64;
    localparam logic [1:0] OP_SPARE = 2'd3;

    class key_table_model;
        logic signed [31:0] keys [TABLE_DEPTH];
        logic [31:0]        vals [TABLE_DEPTH];
        int                 fill;
        int                 errors;
        skt_pkg::result_t   pending_results [$];

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [31:0] any_stored_key();
            return keys[$urandom_range(0, fill - 1)];
        endfunction

        // lower-bound search, then apply the operation to the shadow table
        function void take_request(logic [1:0] op, logic signed [31:0] key, logic [31:0] val);
            int lo;
            int hi;
            int mid;
            int i;
            bit hit;
            skt_pkg::result_t res;
            lo = 0;
            hi = fill;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            hit = (lo < fill) && (keys[lo] == key);
            res = '0;
            res.found = hit;
            res.slot_index = skt_pkg::COUNT_W'(lo);
            res.status = skt_pkg::STAT_OK;
            if (op == skt_pkg::OP_INSERT) begin
                if (hit) begin
                    res.status = skt_pkg::STAT_PRESENT;
                end else if (fill >= TABLE_DEPTH) begin
                    res.status = skt_pkg::STAT_FULL;
                end else begin
                    for (i = fill; i > lo; i--) begin
                        keys[i] = keys[i - 1];
                        vals[i] = vals[i - 1];
                    end
                    keys[lo] = key;
                    vals[lo] = val;
                    fill++;
                end
            end else if (op == skt_pkg::OP_ERASE) begin
                if (!hit) begin
                    res.status = skt_pkg::STAT_ABSENT;
                end else begin
                    for (i = lo + 1; i < fill; i++) begin
                        keys[i - 1] = keys[i];
                        vals[i - 1] = vals[i];
                    end
                    fill--;
                end
            end else begin
                if (hit) res.read_value = vals[lo];
                else res.status = skt_pkg::STAT_ABSENT;
            end
            res.entry_count = skt_pkg::COUNT_W'(fill);
            pending_results = {pending_results, res};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_response(skt_pkg::result_t got);
            skt_pkg::result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            compare_field("pad", 32'(want.pad), 32'(got.pad));
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [skt_pkg::IN_W-1:0]   s_tdata = '0;
    logic [1:0]                 s_tuser = skt_pkg::OP_INSERT;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [skt_pkg::OUT_W-1:0]  m_tdata;

    key_table_model book;
    int tx_burst = 0;
    bit gaps_on = 1'b1;
    int rx_left = 0;
    int rx_style = 0;

    sorted_key_table_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("tb failed");
        $finish;
    end

    // result side: check accepted words, stall in segments of varying style
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.match_response(skt_pkg::result_t'(m_tdata));
        if (rx_left == 0) begin
            rx_left = $urandom_range(1, 40);
            rx_style = $urandom_range(0, 2);
        end
        rx_left--;
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_word(input logic [1:0] op, input logic [31:0] key,
                             input logic [31:0] val);
        if (tx_burst == 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            tx_burst = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {val, key};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.take_request(op, key, val);
        tx_burst--;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        tx_burst = 0;
        while (book.pending() > 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key(logic [1:0] op);
        int r;
        int stored_pct;
        r = $urandom_range(0, 99);
        stored_pct = (op == skt_pkg::OP_INSERT) ? 15 : 55;
        if (r < stored_pct && book.fill > 0) return book.any_stored_key();
        if (r < stored_pct + 25) return 32'(int'($urandom_range(0, 80)) - 40);
        if (r < stored_pct + 32) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        int n_random;
        int ep_len;
        int ep_style;
        int ins_pct;
        int era_pct;
        int r;
        logic [1:0] op;
        book = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, extremes, duplicates, spare kind, erase at both ends
        send_word(skt_pkg::OP_LOOKUP, 32'd0, 32'd0);
        send_word(skt_pkg::OP_ERASE, 32'd5, 32'd0);
        send_word(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(skt_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_word(skt_pkg::OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
        send_word(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_word(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(skt_pkg::OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(OP_SPARE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_SPARE, 32'd12345, 32'h0000_0000);
        send_word(skt_pkg::OP_LOOKUP, 32'd1, 32'h0000_0000);
        send_word(skt_pkg::OP_ERASE, 32'h0000_0000, 32'h0000_0000);
        send_word(skt_pkg::OP_ERASE, 32'h0000_0000, 32'h0000_0000);
        send_word(skt_pkg::OP_ERASE, 32'h8000_0000, 32'h0000_0000);
        send_word(skt_pkg::OP_ERASE, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(skt_pkg::OP_ERASE, 32'hFFFF_FFFF, 32'h0000_0000);
        settle();

        // episodes: fill past capacity first, then filling, mixed and draining runs in random order
        n_random = 0;
        ep_style = 0;
        while (n_random < 1200) begin
            ep_len = (n_random == 0) ? 110 : $urandom_range(40, 120);
            gaps_on = ($urandom_range(0, 3) != 0);
            case (ep_style)
                0: begin ins_pct = 85; era_pct = 5; end
                1: begin ins_pct = 35; era_pct = 30; end
                default: begin ins_pct = 10; era_pct = 70; end
            endcase
            repeat (ep_len) begin
                r = $urandom_range(0, 99);
                if (r < 3) op = OP_SPARE;
                else if (r < 3 + ins_pct) op = skt_pkg::OP_INSERT;
                else if (r < 3 + ins_pct + era_pct) op = skt_pkg::OP_ERASE;
                else op = skt_pkg::OP_LOOKUP;
                send_word(op, pick_key(op), $urandom());
                n_random++;
            end
            if ($urandom_range(0, 2) == 0) settle();
            ep_style = $urandom_range(0, 2);
        end

        settle();
        repeat (200) @(posedge aclk);
        if (book.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
